[rtl/cjls_pkg.sv]
package cjls_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_OTHER  = 2'd0;
	localparam kind_t KIND_CJK    = 2'd1;
	localparam kind_t KIND_WORD   = 2'd2;
	localparam kind_t KIND_EXTEND = 2'd3;

	localparam logic [15:0] AMP_UNIT   = 16'h0026;
	localparam logic [15:0] SPACE_UNIT = 16'h0020;

	localparam int MAX_RES = 4;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	typedef struct packed {
		logic [MAX_RES-1:0][15:0] units;
		logic [CNT_W-1:0]         cnt;
	} res_t;

	typedef struct packed {
		kind_t       pk;
		logic        amp;
		logic        hv;
		logic [15:0] hu;
	} st_t;

	typedef struct packed {
		res_t r;
		st_t  s;
	} acc_t;

	function automatic res_t push(res_t r, logic [15:0] u);
		res_t o;
		o = r;
		if (r.cnt < CNT_W'(MAX_RES)) begin
			o.units[r.cnt[IDX_W-1:0]] = u;
			o.cnt = r.cnt + CNT_W'(1);
		end
		return o;
	endfunction

	// optional space, held mark, then one or two units of the code point
	function automatic acc_t token(acc_t a, kind_t k, logic [15:0] u0, logic [15:0] u1,
			logic two);
		acc_t o;
		o = a;
		if (k != KIND_EXTEND && ((o.s.pk == KIND_CJK && k == KIND_WORD) ||
				(o.s.pk == KIND_WORD && k == KIND_CJK))) begin
			o.r = push(o.r, SPACE_UNIT);
		end
		if (o.s.amp) begin
			o.r = push(o.r, AMP_UNIT);
		end
		o.r = push(o.r, u0);
		if (two) begin
			o.r = push(o.r, u1);
		end
		if (k != KIND_EXTEND) begin
			o.s.pk = k;
		end
		o.s.amp = 1'b0;
		return o;
	endfunction

endpackage

[rtl/cjls_class.sv]
module cjls_class
	import cjls_pkg::*;
(
	input  logic [20:0] cp,
	output kind_t       kind
);

	logic ext, cjk, word;

	assign ext = (cp >= 21'h00300 && cp <= 21'h0036F) || (cp >= 21'h01AB0 && cp <= 21'h01AFF) ||
		(cp >= 21'h01DC0 && cp <= 21'h01DFF) || (cp >= 21'h020D0 && cp <= 21'h020FF) ||
		(cp >= 21'h0FE00 && cp <= 21'h0FE0F) || (cp >= 21'h0FE20 && cp <= 21'h0FE2F) ||
		(cp >= 21'h0FF9E && cp <= 21'h0FF9F) || (cp >= 21'hE0100 && cp <= 21'hE01EF);

	assign cjk = (cp >= 21'h01100 && cp <= 21'h011FF) || (cp >= 21'h02E80 && cp <= 21'h02FDF) ||
		cp == 21'h03005 || cp == 21'h03007 ||
		(cp >= 21'h03040 && cp <= 21'h030FF) || (cp >= 21'h03100 && cp <= 21'h0318F) ||
		(cp >= 21'h031A0 && cp <= 21'h031FF) ||
		(cp >= 21'h03400 && cp <= 21'h04DBF) || (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
		(cp >= 21'h0F900 && cp <= 21'h0FAFF) || (cp >= 21'h0A960 && cp <= 21'h0A97F) ||
		(cp >= 21'h0AC00 && cp <= 21'h0D7FF) || (cp >= 21'h0FF66 && cp <= 21'h0FF9D) ||
		(cp >= 21'h1B000 && cp <= 21'h1B16F) || (cp >= 21'h20000 && cp <= 21'h2FA1F) ||
		(cp >= 21'h30000 && cp <= 21'h323AF);

	assign word = (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h41 && cp <= 21'h5A) ||
		(cp >= 21'h61 && cp <= 21'h7A);

	always_comb begin
		priority if (ext) begin
			kind = KIND_EXTEND;
		end else if (cjk) begin
			kind = KIND_CJK;
		end else if (word) begin
			kind = KIND_WORD;
		end else begin
			kind = KIND_OTHER;
		end
	end

endmodule

[rtl/cjls_step.sv]
module cjls_step
	import cjls_pkg::*;
(
	input  logic [15:0] text_unit,
	input  logic        text_end,
	input  logic        keep,
	input  st_t         st,
	output res_t        res,
	output st_t         st_next
);

	logic [20:0] cp_u, cp_h, cp_pair;
	kind_t       k_u, k_h, k_pair;
	logic        is_low, is_high, is_amp;

	assign cp_u    = {5'd0, text_unit};
	assign cp_h    = {5'd0, st.hu};
	assign cp_pair = {1'b0, st.hu[9:0], text_unit[9:0]} + 21'h10000;
	assign is_low  = text_unit[15:10] == 6'b110111;
	assign is_high = text_unit[15:10] == 6'b110110;
	assign is_amp  = text_unit == AMP_UNIT;

	cjls_class u_class_u    (.cp(cp_u),    .kind(k_u));
	cjls_class u_class_h    (.cp(cp_h),    .kind(k_h));
	cjls_class u_class_pair (.cp(cp_pair), .kind(k_pair));

	always_comb begin
		acc_t a;
		logic done;
		a     = '0;
		a.s   = st;
		done  = 1'b0;
		if (st.hv) begin
			a.s.hv = 1'b0;
			if (is_low) begin
				a    = token(a, k_pair, st.hu, text_unit, 1'b1);
				done = 1'b1;
			end else begin
				a = token(a, k_h, st.hu, 16'h0000, 1'b0);
			end
		end
		if (!done) begin
			priority if (a.s.amp && is_amp) begin
				a.r     = push(a.r, AMP_UNIT);
				a.r     = push(a.r, AMP_UNIT);
				a.s.pk  = KIND_OTHER;
				a.s.amp = 1'b0;
			end else if (!a.s.amp && is_amp && keep) begin
				a.s.amp = 1'b1;
			end else if (is_high) begin
				a.s.hv = 1'b1;
				a.s.hu = text_unit;
			end else begin
				a = token(a, k_u, text_unit, 16'h0000, 1'b0);
			end
		end
		if (text_end) begin
			// a high surrogate held here is always the current unit
			if (a.s.hv) begin
				a = token(a, k_u, a.s.hu, 16'h0000, 1'b0);
			end else if (a.s.amp) begin
				a.r = push(a.r, AMP_UNIT);
			end
			a.s = '0;
		end
		res     = a.r;
		st_next = a.s;
	end

endmodule

[rtl/cjls_ser.sv]
module cjls_ser
	import cjls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	input  logic        res_end,
	output logic        can_load,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_unit,
	output logic        run_last,
	output logic        text_done
);

	logic [MAX_RES-1:0][15:0] units_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     end_q;
	logic                     valid_q;
	logic                     last, take;

	assign last      = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
	assign take      = valid_q && out_ready;
	assign can_load  = !valid_q || (take && last);
	assign out_valid = valid_q;
	assign out_unit  = units_q[idx_q];
	assign run_last  = last;
	assign text_done = last && end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			units_q <= res.units;
			cnt_q   <= res.cnt;
			end_q   <= res_end;
		end
	end

	property p_idx_in_range;
		@(posedge clk) disable iff (!arst_n)
		valid_q |-> (CNT_W'(idx_q) < cnt_q);
	endproperty
	a_idx_in_range: assert property (p_idx_in_range) else $error("index past word count");

endmodule

[rtl/cjk_latin_boundary_spacer.sv]
// A word is held in the input register, then its results load the output serializer.
// Throughput: one input word per cycle while each word yields at most one result
// and out_ready is high; a word yielding more (up to four) holds the serializer
// until all are taken. Words that yield nothing never load the serializer.
// Reset (arst_n low): control and step state cleared, keep_mnemonic_marks set to 1.
module cjk_latin_boundary_spacer
	import cjls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] text_unit,
	input  logic        text_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_unit,
	output logic        run_last,
	output logic        text_done
);

	logic        keep_q;
	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        end_s1;
	st_t         st_q, st_next;
	res_t        res;
	logic        can_load, adv, load;

	assign adv      = valid_s1 && (res.cnt == '0 || can_load);
	assign load     = adv && res.cnt != '0;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b1;
		end else if (cfg_wr_en) begin
			keep_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			unit_s1 <= text_unit;
			end_s1  <= text_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	cjls_step u_step (
		.text_unit (unit_s1),
		.text_end  (end_s1),
		.keep      (keep_q),
		.st        (st_q),
		.res       (res),
		.st_next   (st_next)
	);

	cjls_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.res_end   (end_s1),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_unit  (out_unit),
		.run_last  (run_last),
		.text_done (text_done)
	);

	property p_end_clears;
		@(posedge clk) disable iff (!arst_n)
		(adv && end_s1) |=> (st_q.pk == KIND_OTHER && !st_q.amp && !st_q.hv);
	endproperty
	a_end_clears: assert property (p_end_clears) else $error("state not cleared at text end");

	property p_held_is_high;
		@(posedge clk) disable iff (!arst_n)
		st_q.hv |-> (st_q.hu[15:10] == 6'b110110);
	endproperty
	a_held_is_high: assert property (p_held_is_high) else $error("held unit not a high half");

	property p_s1_holds;
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(unit_s1) && $stable(end_s1));
	endproperty
	a_s1_holds: assert property (p_s1_holds) else $error("stalled word lost");

endmodule
